/* rtl/core/fbmd_pkg.sv */
// shared types, widths and codes for the mono framebuffer downscaler
`default_nettype none
package fbmd_pkg;

    // default geometry
    localparam int SRC_WIDTH_DEF  = 160;
    localparam int SRC_HEIGHT_DEF = 144;
    localparam int OUT_WIDTH_DEF  = 128;
    localparam int OUT_HEIGHT_DEF = 64;

    // payload field widths
    localparam int OPCODE_W = 1;
    localparam int ADDR_W   = 13;
    localparam int DATA_W   = 8;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 4;
    localparam int PAN_W    = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // a row is at most this many bytes of eight pixels
    localparam int MAX_ROW_BYTES = 16;
    localparam int PIX_IDX_W     = 7;
    localparam int ROW_MAX       = 63;
    // width of output coordinate plus pan, signed
    localparam int PAN_SUM_W     = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAN_X      = 2'd0,
        REG_PAN_Y      = 2'd1,
        REG_SCALE_MODE = 2'd2
    } t_reg_idx;

    // controller to datapath
    typedef struct packed {
        logic                 mem_wr;
        logic                 start;
        logic                 y_step;
        logic                 base_load;
        logic                 pix_issue;
        logic [PIX_IDX_W-1:0] pix_idx;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic y_done;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/core/fbmd_if.sv */
// request and result channel interfaces
`default_nettype none
interface fbmd_in_if;
    logic                          valid;
    logic                          ready;
    logic [fbmd_pkg::OPCODE_W-1:0] opcode;
    logic [fbmd_pkg::ADDR_W-1:0]   fb_address;
    logic [fbmd_pkg::DATA_W-1:0]   fb_data;
    logic [fbmd_pkg::ROW_W-1:0]    render_row;

    modport source (output valid, output opcode, output fb_address, output fb_data,
                    output render_row, input ready);
    modport sink (input valid, input opcode, input fb_address, input fb_data,
                  input render_row, output ready);
endinterface

interface fbmd_out_if;
    logic                       valid;
    logic                       ready;
    logic [fbmd_pkg::ROW_W-1:0] out_row;
    logic [fbmd_pkg::COL_W-1:0] out_column_byte;
    logic [7:0]                 out_bits;
    logic                       last;

    modport source (output valid, output out_row, output out_column_byte,
                    output out_bits, output last, input ready);
    modport sink (input valid, input out_row, input out_column_byte,
                  input out_bits, input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/fbmd_ctrl.sv */
// sequencer for framebuffer writes and row rendering
`default_nettype none
module fbmd_ctrl #(
    parameter int OUT_WIDTH = fbmd_pkg::OUT_WIDTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    fbmd_in_if.sink         i_req,
    input  fbmd_pkg::t_stat i_stat,
    output fbmd_pkg::t_ctrl o_cmd
);

    localparam int NBYTES_RAW = (OUT_WIDTH + 7) / 8;
    localparam int NBYTES = (NBYTES_RAW > fbmd_pkg::MAX_ROW_BYTES) ?
                            fbmd_pkg::MAX_ROW_BYTES : NBYTES_RAW;
    localparam int PIX = NBYTES * 8;
    localparam logic [fbmd_pkg::PIX_IDX_W-1:0] PIX_LAST = fbmd_pkg::PIX_IDX_W'(PIX - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_YMAP,
        S_BASE,
        S_PIXEL
    } t_state;

    t_state                         r_state, n_state;
    logic [fbmd_pkg::PIX_IDX_W-1:0] r_pix, n_pix;
    logic                           fire;

    assign i_req.ready = (r_state == S_IDLE);
    assign fire        = i_req.valid && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_pix           = r_pix;
        o_cmd           = '0;
        o_cmd.pix_idx   = r_pix;
        case (r_state)
            S_IDLE: begin
                if (fire) begin
                    if (i_req.opcode == fbmd_pkg::OP_WRITE) begin
                        o_cmd.mem_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_YMAP;
                    end
                end
            end
            S_YMAP: begin
                if (i_stat.y_done) begin
                    n_state = S_BASE;
                end else begin
                    o_cmd.y_step = 1'b1;
                end
            end
            S_BASE: begin
                o_cmd.base_load = 1'b1;
                n_pix           = '0;
                n_state         = S_PIXEL;
            end
            S_PIXEL: begin
                // the last pixel of a byte waits for a free output register
                if (!((r_pix[2:0] == 3'd7) && i_stat.out_busy)) begin
                    o_cmd.pix_issue = 1'b1;
                    n_pix           = r_pix + 1'b1;
                    if (r_pix == PIX_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pix   <= '0;
        end else begin
            r_state <= n_state;
            r_pix   <= n_pix;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/fbmd_dp.sv */
// framebuffer memory, coordinate mapping and byte assembly
`default_nettype none
module fbmd_dp #(
    parameter int SRC_WIDTH  = fbmd_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = fbmd_pkg::SRC_HEIGHT_DEF,
    parameter int OUT_WIDTH  = fbmd_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = fbmd_pkg::OUT_HEIGHT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    fbmd_in_if.sink                             i_req,
    fbmd_out_if.source                          o_rsp,
    input  wire                                 i_cfg_we,
    input  wire [fbmd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [fbmd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  fbmd_pkg::t_ctrl                     i_cmd,
    output fbmd_pkg::t_stat                     o_stat
);

    localparam int FB_DEPTH = (SRC_WIDTH * SRC_HEIGHT + 3) / 4;
    localparam int A_W      = $clog2(FB_DEPTH);
    localparam int P_W      = A_W + 2;
    localparam int SX_W     = $clog2(SRC_WIDTH);
    localparam int SY_W     = $clog2(SRC_HEIGHT);
    localparam int PW       = fbmd_pkg::PIX_IDX_W;
    localparam int RW       = fbmd_pkg::ROW_W;

    localparam int NBYTES_RAW = (OUT_WIDTH + 7) / 8;
    localparam int NBYTES = (NBYTES_RAW > fbmd_pkg::MAX_ROW_BYTES) ?
                            fbmd_pkg::MAX_ROW_BYTES : NBYTES_RAW;
    localparam int PIX = NBYTES * 8;

    // incremental quotient and remainder of (2*src*o + dst) / (2*dst)
    localparam int XQ_MAX = (2 * SRC_WIDTH * PIX + OUT_WIDTH) / (2 * OUT_WIDTH);
    localparam int XQ_W   = $clog2(XQ_MAX + 1);
    localparam int XR_W   = $clog2(4 * OUT_WIDTH);
    localparam int YQ_MAX = (2 * SRC_HEIGHT * (fbmd_pkg::ROW_MAX + 1) + OUT_HEIGHT) /
                            (2 * OUT_HEIGHT);
    localparam int YQ_W   = $clog2(YQ_MAX + 1);
    localparam int YR_W   = $clog2(4 * OUT_HEIGHT);

    localparam logic [XQ_W-1:0] XQ_STEP = XQ_W'(SRC_WIDTH / OUT_WIDTH);
    localparam logic [XR_W-1:0] XR_STEP = XR_W'((2 * SRC_WIDTH) % (2 * OUT_WIDTH));
    localparam logic [XR_W-1:0] XR_MOD  = XR_W'(2 * OUT_WIDTH);
    localparam logic [XR_W-1:0] XR_INIT = XR_W'(OUT_WIDTH);
    localparam logic [YQ_W-1:0] YQ_STEP = YQ_W'(SRC_HEIGHT / OUT_HEIGHT);
    localparam logic [YR_W-1:0] YR_STEP = YR_W'((2 * SRC_HEIGHT) % (2 * OUT_HEIGHT));
    localparam logic [YR_W-1:0] YR_MOD  = YR_W'(2 * OUT_HEIGHT);
    localparam logic [YR_W-1:0] YR_INIT = YR_W'(OUT_HEIGHT);

    // signed width for clamping either mode
    localparam int MQ = (XQ_W > YQ_W) ? XQ_W : YQ_W;
    localparam int CW = ((MQ > fbmd_pkg::PAN_SUM_W) ? MQ : fbmd_pkg::PAN_SUM_W) + 2;
    localparam logic signed [CW-1:0] SW_C  = CW'(SRC_WIDTH);
    localparam logic signed [CW-1:0] SH_C  = CW'(SRC_HEIGHT);
    localparam logic [SX_W-1:0]      SX_MAX = SX_W'(SRC_WIDTH - 1);
    localparam logic [SY_W-1:0]      SY_MAX = SY_W'(SRC_HEIGHT - 1);
    localparam logic [P_W-1:0]       SW_P  = P_W'(SRC_WIDTH);
    localparam logic [PW-1:0]        PIX_LAST = PW'(PIX - 1);
    localparam logic [PW-1:0]        OW_P  = PW'((OUT_WIDTH > PIX) ? PIX : OUT_WIDTH);
    localparam logic                 MASK_ALL = (OUT_WIDTH >= PIX);

    // configuration
    logic [fbmd_pkg::PAN_W-1:0] r_pan_x, r_pan_y;
    logic                       r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_x <= '0;
            r_pan_y <= '0;
            r_scale <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbmd_pkg::REG_PAN_X:      r_pan_x <= i_cfg_data[fbmd_pkg::PAN_W-1:0];
                fbmd_pkg::REG_PAN_Y:      r_pan_y <= i_cfg_data[fbmd_pkg::PAN_W-1:0];
                fbmd_pkg::REG_SCALE_MODE: r_scale <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // row mapping
    logic [RW-1:0]   r_row, r_ycnt;
    logic [YQ_W-1:0] r_yq;
    logic [YR_W-1:0] r_yr;
    logic [YR_W-1:0] yr_sum;
    logic signed [CW-1:0] y_raw;
    logic [SY_W-1:0] sy;

    assign yr_sum = r_yr + YR_STEP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row  <= i_req.render_row;
            r_ycnt <= '0;
            r_yq   <= '0;
            r_yr   <= YR_INIT;
        end else if (i_cmd.y_step) begin
            r_ycnt <= r_ycnt + 1'b1;
            if (yr_sum >= YR_MOD) begin
                r_yr <= yr_sum - YR_MOD;
                r_yq <= r_yq + YQ_STEP + 1'b1;
            end else begin
                r_yr <= yr_sum;
                r_yq <= r_yq + YQ_STEP;
            end
        end
    end

    assign o_stat.y_done = !r_scale || (r_ycnt == r_row);

    always_comb begin
        if (r_scale) begin
            y_raw = {{(CW - YQ_W){1'b0}}, r_yq};
        end else begin
            y_raw = {{(CW - fbmd_pkg::PAN_W){r_pan_y[fbmd_pkg::PAN_W-1]}}, r_pan_y}
                  + {{(CW - RW){1'b0}}, r_row};
        end
        if (y_raw < 0) begin
            sy = '0;
        end else if (y_raw >= SH_C) begin
            sy = SY_MAX;
        end else begin
            sy = y_raw[SY_W-1:0];
        end
    end

    logic [P_W-1:0] r_base;

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_load) begin
            r_base <= P_W'(sy) * SW_P;
        end
    end

    // column mapping, one pixel per issue
    logic [XQ_W-1:0] r_xq;
    logic [XR_W-1:0] r_xr;
    logic [XR_W-1:0] xr_sum;
    logic signed [CW-1:0] x_raw;
    logic [SX_W-1:0] sx;
    logic [P_W-1:0]  pix_addr;

    assign xr_sum = r_xr + XR_STEP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_xq <= '0;
            r_xr <= XR_INIT;
        end else if (i_cmd.pix_issue) begin
            if (xr_sum >= XR_MOD) begin
                r_xr <= xr_sum - XR_MOD;
                r_xq <= r_xq + XQ_STEP + 1'b1;
            end else begin
                r_xr <= xr_sum;
                r_xq <= r_xq + XQ_STEP;
            end
        end
    end

    always_comb begin
        if (r_scale) begin
            x_raw = {{(CW - XQ_W){1'b0}}, r_xq};
        end else begin
            x_raw = {{(CW - fbmd_pkg::PAN_W){r_pan_x[fbmd_pkg::PAN_W-1]}}, r_pan_x}
                  + {{(CW - PW){1'b0}}, i_cmd.pix_idx};
        end
        if (x_raw < 0) begin
            sx = '0;
        end else if (x_raw >= SW_C) begin
            sx = SX_MAX;
        end else begin
            sx = x_raw[SX_W-1:0];
        end
    end

    assign pix_addr = r_base + P_W'(sx);

    // single-port frame store
    logic [7:0]     mem [FB_DEPTH];
    logic [7:0]     r_rdata;
    logic           wr_fire;
    logic [A_W-1:0] mem_addr;

    assign wr_fire  = i_cmd.mem_wr && (int'(i_req.fb_address) < FB_DEPTH);
    assign mem_addr = i_cmd.mem_wr ? A_W'(i_req.fb_address) : pix_addr[P_W-1:2];

    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            mem[mem_addr] <= i_req.fb_data;
        end
        r_rdata <= mem[mem_addr];
    end

    // read stage bookkeeping
    logic          r_s1_v;
    logic [PW-1:0] r_s1_idx;
    logic [1:0]    r_s1_sel;
    logic          r_s1_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.pix_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_issue) begin
            r_s1_idx  <= i_cmd.pix_idx;
            r_s1_sel  <= pix_addr[1:0];
            // pixels past the screen edge in a partial byte read as zero
            r_s1_mask <= MASK_ALL || (i_cmd.pix_idx < OW_P);
        end
    end

    // byte assembly and output register
    logic       pix_bit;
    logic       land_byte;
    logic [6:0] r_acc;
    logic       r_out_v;
    logic [RW-1:0] r_out_row;
    logic [fbmd_pkg::COL_W-1:0] r_out_col;
    logic [7:0] r_out_bits;
    logic       r_out_last;

    assign pix_bit   = r_s1_mask && r_rdata[{r_s1_sel, 1'b0}];
    assign land_byte = r_s1_v && (r_s1_idx[2:0] == 3'd7);

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_acc <= {r_acc[5:0], pix_bit};
        end
        if (land_byte) begin
            r_out_bits <= {r_acc, pix_bit};
            r_out_row  <= r_row;
            r_out_col  <= r_s1_idx[PW-1:3];
            r_out_last <= (r_s1_idx == PIX_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (land_byte) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_stat.out_busy      = r_out_v;
    assign o_rsp.valid          = r_out_v;
    assign o_rsp.out_row        = r_out_row;
    assign o_rsp.out_column_byte = r_out_col;
    assign o_rsp.out_bits       = r_out_bits;
    assign o_rsp.last           = r_out_last;

endmodule
`default_nettype wire

/* rtl/core/framebuffer_mono_downscaler_top.sv */
// top level of the mono framebuffer downscaler
// write request: stored at the accepting edge, next request the cycle after
// render request: accept, row mapping that steps once per render row in scale mode,
//   one row base load, then 128 pixel reads one per cycle, save where a byte's last read waits
// a byte passes the memory read register, then the output register; its last pixel read waits while a byte is held
// reset clears control and configuration; the frame store is undefined until written
`default_nettype none
module framebuffer_mono_downscaler_top #(
    parameter int SRC_WIDTH  = fbmd_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = fbmd_pkg::SRC_HEIGHT_DEF,
    parameter int OUT_WIDTH  = fbmd_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = fbmd_pkg::OUT_HEIGHT_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    fbmd_in_if.sink                        i_req,
    fbmd_out_if.source                     o_rsp,
    input  wire                            i_cfg_we,
    input  wire [fbmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [fbmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fbmd_pkg::t_ctrl cmd;
    fbmd_pkg::t_stat stat;

    fbmd_ctrl #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fbmd_dp #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule
`default_nettype wire
